// ----- sv/jwtexp_pkg.sv -----
package jwtexp_pkg;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PAD    = 8'h3D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [62:0] ACC_MAX = {63{1'b1}};

    localparam logic [2:0] VERD_NONE     = 3'd0;
    localparam logic [2:0] VERD_NO_KEY   = 3'd1;
    localparam logic [2:0] VERD_NO_COLON = 3'd2;
    localparam logic [2:0] VERD_NO_DIGIT = 3'd3;
    localparam logic [2:0] VERD_COMPARED = 3'd4;

    typedef enum logic [1:0] {
        SEG_HEAD = 2'd0,
        SEG_BODY = 2'd1,
        SEG_TAIL = 2'd2
    } t_seg;

    typedef enum logic [3:0] {
        S_KEY0  = 4'd0,
        S_KEY1  = 4'd1,
        S_KEY2  = 4'd2,
        S_KEY3  = 4'd3,
        S_KEY4  = 4'd4,
        S_COLON = 4'd5,
        S_BLANK = 4'd6,
        S_DIGIT = 4'd7,
        S_NODIG = 4'd8,
        S_DONE  = 4'd9
    } t_search;

    typedef struct packed {
        t_search     search;
        logic [62:0] accum;
        logic        ovf;
        logic        nonempty;
    } t_match;

    localparam t_match MATCH_INIT = '{search: S_KEY0, accum: '0, ovf: 1'b0, nonempty: 1'b0};

    typedef struct packed {
        logic [7:0]         token_byte;
        logic               last_byte;
        logic signed [63:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic        expired;
        logic [2:0]  verdict;
        logic [62:0] expiry_value;
        logic        expiry_saturated;
    } t_out_item;

endpackage

// ----- sv/jwtexp_match.sv -----
module jwtexp_match (
    input  jwtexp_pkg::t_match i_state,
    input  logic [23:0]        i_bits,
    input  logic [2:0]         i_en,
    output jwtexp_pkg::t_match o_state
);

    function automatic jwtexp_pkg::t_match step(input jwtexp_pkg::t_match st,
                                                input logic [7:0] c);
        jwtexp_pkg::t_match r;
        logic               digit;
        logic [62:0]        d;
        logic [66:0]        prod;
        r     = st;
        digit = (c >= jwtexp_pkg::CH_ZERO) && (c <= jwtexp_pkg::CH_NINE);
        d     = {59'd0, c[3:0]};
        prod  = ({4'd0, st.accum} << 3) + ({4'd0, st.accum} << 1) + {4'd0, d};
        r.nonempty = 1'b1;
        case (st.search)
            jwtexp_pkg::S_KEY0: begin
                r.search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_KEY1
                                                       : jwtexp_pkg::S_KEY0;
            end
            jwtexp_pkg::S_KEY1: begin
                if (c == jwtexp_pkg::CH_E) r.search = jwtexp_pkg::S_KEY2;
                else r.search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_KEY1
                                                            : jwtexp_pkg::S_KEY0;
            end
            jwtexp_pkg::S_KEY2: begin
                if (c == jwtexp_pkg::CH_X) r.search = jwtexp_pkg::S_KEY3;
                else r.search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_KEY1
                                                            : jwtexp_pkg::S_KEY0;
            end
            jwtexp_pkg::S_KEY3: begin
                if (c == jwtexp_pkg::CH_P) r.search = jwtexp_pkg::S_KEY4;
                else r.search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_KEY1
                                                            : jwtexp_pkg::S_KEY0;
            end
            jwtexp_pkg::S_KEY4: begin
                r.search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_COLON
                                                       : jwtexp_pkg::S_KEY0;
            end
            jwtexp_pkg::S_COLON: begin
                if (c == jwtexp_pkg::CH_COLON) r.search = jwtexp_pkg::S_BLANK;
            end
            jwtexp_pkg::S_BLANK: begin
                if (digit) begin
                    r.accum  = d;
                    r.search = jwtexp_pkg::S_DIGIT;
                end else if (c != jwtexp_pkg::CH_SPACE && c != jwtexp_pkg::CH_TAB) begin
                    r.search = jwtexp_pkg::S_NODIG;
                end
            end
            jwtexp_pkg::S_DIGIT: begin
                if (digit) begin
                    // saturate once the run leaves the 63-bit range
                    if (st.ovf || (prod[66:63] != 4'd0)) begin
                        r.accum = jwtexp_pkg::ACC_MAX;
                        r.ovf   = 1'b1;
                    end else begin
                        r.accum = prod[62:0];
                    end
                end else begin
                    r.search = jwtexp_pkg::S_DONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    jwtexp_pkg::t_match s0;
    jwtexp_pkg::t_match s1;
    jwtexp_pkg::t_match s2;

    always_comb begin
        s0      = i_en[0] ? step(i_state, i_bits[23:16]) : i_state;
        s1      = i_en[1] ? step(s0, i_bits[15:8]) : s0;
        s2      = i_en[2] ? step(s1, i_bits[7:0]) : s1;
        o_state = s2;
    end

endmodule

// ----- sv/jwt_expiry_stream_check_core.sv -----
// Token expiry checker: streams a token one byte per request and reports
// whether its "exp" claim has passed.
// Input channel: i_in_valid / o_in_stall with i_in_item (token byte, last
// flag, current time). The payload segment is base64-decoded (+/ or -_)
// and each decoded byte feeds the key, colon and digit matcher in the
// same cycle, so one byte is accepted per clock while o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_out_item. Only a byte
// marked last produces a request: verdict, expiry flag, parsed value and
// saturation flag. Its token state is captured in the holding stage,
// then the time compare result is loaded into the output register once
// that register is free.
// The byte and the result paths are decoupled by a result holding stage
// and the output register, so bytes keep flowing while a result waits.
// o_in_stall rises only when both the holding stage and the output
// register carry results and the receiver is stalling.
// The last byte returns all token state to its initial value.
// Reset (i_rst_n low, synchronous) clears the token state and drops any
// pending results.
module jwt_expiry_stream_check_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  jwtexp_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output jwtexp_pkg::t_out_item o_out_item
);

    typedef struct packed {
        logic               seg_ok;
        jwtexp_pkg::t_match match;
        logic signed [63:0] time_now;
    } t_fin;

    function automatic logic [5:0] sextet(input logic [7:0] c);
        logic [5:0] s;
        if (c >= 8'h41 && c <= 8'h5A) s = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) s = 6'(c - 8'h61 + 8'd26);
        else if (c >= jwtexp_pkg::CH_ZERO && c <= jwtexp_pkg::CH_NINE)
            s = 6'(c - jwtexp_pkg::CH_ZERO + 8'd52);
        else if (c == jwtexp_pkg::CH_PLUS || c == jwtexp_pkg::CH_DASH) s = 6'd62;
        else if (c == jwtexp_pkg::CH_SLASH || c == jwtexp_pkg::CH_UNDER) s = 6'd63;
        else s = 6'd0;
        return s;
    endfunction

    jwtexp_pkg::t_seg   r_seg, n_seg;
    logic [23:0]        r_qbits, n_qbits;
    logic [1:0]         r_qfill, n_qfill;
    logic [2:0]         r_pad, n_pad;
    jwtexp_pkg::t_match r_match, n_match;

    logic               r_fin_valid;
    t_fin               r_fin;
    logic               r_out_valid;
    jwtexp_pkg::t_out_item r_out, n_out;

    logic        accept;
    logic        fin_move;
    logic [7:0]  c;
    logic        flush;
    logic [23:0] fbits;
    logic [2:0]  fpad;
    logic [23:0] shifted;
    logic [2:0]  pad_inc;
    logic [2:0]  en;

    assign accept   = i_in_valid && !o_in_stall;
    assign fin_move = r_fin_valid && (!r_out_valid || !i_out_stall);
    assign c        = i_in_item.token_byte & jwtexp_pkg::BYTE_MASK;

    // segment tracking and quartet gathering
    always_comb begin
        n_seg   = r_seg;
        n_qbits = r_qbits;
        n_qfill = r_qfill;
        n_pad   = r_pad;
        flush   = 1'b0;
        fbits   = '0;
        fpad    = '0;
        shifted = {r_qbits[17:0], (c == jwtexp_pkg::CH_PAD) ? 6'd0 : sextet(c)};
        pad_inc = r_pad + {2'd0, (c == jwtexp_pkg::CH_PAD)};
        case (r_seg)
            jwtexp_pkg::SEG_HEAD: begin
                if (c == jwtexp_pkg::CH_DOT) n_seg = jwtexp_pkg::SEG_BODY;
            end
            jwtexp_pkg::SEG_BODY: begin
                if (c == jwtexp_pkg::CH_DOT) begin
                    n_seg   = jwtexp_pkg::SEG_TAIL;
                    n_qbits = '0;
                    n_qfill = '0;
                    n_pad   = '0;
                    // complete an open quartet with padding
                    case (r_qfill)
                        2'd1: begin
                            flush = 1'b1;
                            fbits = {r_qbits[5:0], 18'd0};
                            fpad  = r_pad + 3'd3;
                        end
                        2'd2: begin
                            flush = 1'b1;
                            fbits = {r_qbits[11:0], 12'd0};
                            fpad  = r_pad + 3'd2;
                        end
                        2'd3: begin
                            flush = 1'b1;
                            fbits = {r_qbits[17:0], 6'd0};
                            fpad  = r_pad + 3'd1;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_qfill == 2'd3) begin
                    flush   = 1'b1;
                    fbits   = shifted;
                    fpad    = pad_inc;
                    n_qbits = '0;
                    n_qfill = '0;
                    n_pad   = '0;
                end else begin
                    n_qbits = shifted;
                    n_qfill = r_qfill + 2'd1;
                    n_pad   = pad_inc;
                end
            end
            default: begin
            end
        endcase
        en[0] = flush && (fpad < 3'd3);
        en[1] = flush && (fpad < 3'd2);
        en[2] = flush && (fpad == 3'd0);
    end

    jwtexp_match u_match (
        .i_state (r_match),
        .i_bits  (fbits),
        .i_en    (en),
        .o_state (n_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= jwtexp_pkg::SEG_HEAD;
            r_qbits <= '0;
            r_qfill <= '0;
            r_pad   <= '0;
            r_match <= jwtexp_pkg::MATCH_INIT;
        end else if (accept) begin
            if (i_in_item.last_byte) begin
                r_seg   <= jwtexp_pkg::SEG_HEAD;
                r_qbits <= '0;
                r_qfill <= '0;
                r_pad   <= '0;
                r_match <= jwtexp_pkg::MATCH_INIT;
            end else begin
                r_seg   <= n_seg;
                r_qbits <= n_qbits;
                r_qfill <= n_qfill;
                r_pad   <= n_pad;
                r_match <= n_match;
            end
        end
    end

    // hold the final token state until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (accept && i_in_item.last_byte) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last_byte) begin
            r_fin.seg_ok   <= (n_seg == jwtexp_pkg::SEG_TAIL);
            r_fin.match    <= n_match;
            r_fin.time_now <= i_in_item.time_now;
        end
    end

    always_comb begin
        n_out.expired          = 1'b1;
        n_out.verdict          = jwtexp_pkg::VERD_NONE;
        n_out.expiry_value     = '0;
        n_out.expiry_saturated = 1'b0;
        if (r_fin.seg_ok && r_fin.match.nonempty) begin
            case (r_fin.match.search)
                jwtexp_pkg::S_KEY0, jwtexp_pkg::S_KEY1, jwtexp_pkg::S_KEY2,
                jwtexp_pkg::S_KEY3, jwtexp_pkg::S_KEY4: begin
                    n_out.verdict = jwtexp_pkg::VERD_NO_KEY;
                    n_out.expired = 1'b0;
                end
                jwtexp_pkg::S_COLON: begin
                    n_out.verdict = jwtexp_pkg::VERD_NO_COLON;
                end
                jwtexp_pkg::S_DIGIT, jwtexp_pkg::S_DONE: begin
                    n_out.verdict          = jwtexp_pkg::VERD_COMPARED;
                    n_out.expiry_value     = r_fin.match.accum;
                    n_out.expiry_saturated = r_fin.match.ovf;
                    // a negative time never reaches the expiry
                    n_out.expired = !r_fin.time_now[63]
                                    && (r_fin.time_now[62:0] >= r_fin.match.accum);
                end
                default: begin
                    n_out.verdict = jwtexp_pkg::VERD_NO_DIGIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = r_fin_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- tb/tb.sv -----
module tb;

    typedef logic [7:0] t_bytes[$];

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    jwtexp_pkg::t_in_item  i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    jwtexp_pkg::t_out_item o_out_item;

    jwt_expiry_stream_check_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Predicted token state
    jwtexp_pkg::t_seg    claim_seg;
    logic [23:0]         claim_bits;
    logic [2:0]          claim_fill;
    logic [2:0]          claim_pads;
    logic                claim_nonempty;
    jwtexp_pkg::t_search claim_search;
    logic [62:0]         claim_accum;
    logic                claim_sat;

    jwtexp_pkg::t_out_item pending_verdicts[$];

    int errors         = 0;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int tokens_seen    = 0;
    int n_compared     = 0;
    int n_saturated    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d verdicts outstanding", $time, pending_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    function automatic void note_error(input string msg);
        errors++;
        $display("%0t ERROR %s", $time, msg);
    endfunction

    function automatic void claim_reset();
        claim_seg      = jwtexp_pkg::SEG_HEAD;
        claim_bits     = '0;
        claim_fill     = '0;
        claim_pads     = '0;
        claim_nonempty = 1'b0;
        claim_search   = jwtexp_pkg::S_KEY0;
        claim_accum    = '0;
        claim_sat      = 1'b0;
    endfunction

    // Advance the key / colon / digit matcher by one decoded byte
    function automatic void feed_decoded(input logic [7:0] c);
        logic [63:0] d;
        logic        is_digit;
        logic [7:0]  want;
        d = {56'd0, c - jwtexp_pkg::CH_ZERO};
        is_digit = (c >= jwtexp_pkg::CH_ZERO) && (c <= jwtexp_pkg::CH_NINE);
        claim_nonempty = 1'b1;
        if (claim_search <= jwtexp_pkg::S_KEY4) begin
            case (claim_search)
                jwtexp_pkg::S_KEY1: want = jwtexp_pkg::CH_E;
                jwtexp_pkg::S_KEY2: want = jwtexp_pkg::CH_X;
                jwtexp_pkg::S_KEY3: want = jwtexp_pkg::CH_P;
                default:            want = jwtexp_pkg::CH_QUOTE;
            endcase
            if (c == want) claim_search = jwtexp_pkg::t_search'(claim_search + 4'd1);
            else claim_search = (c == jwtexp_pkg::CH_QUOTE) ? jwtexp_pkg::S_KEY1
                                                            : jwtexp_pkg::S_KEY0;
        end else begin
            case (claim_search)
                jwtexp_pkg::S_COLON: begin
                    if (c == jwtexp_pkg::CH_COLON) claim_search = jwtexp_pkg::S_BLANK;
                end
                jwtexp_pkg::S_BLANK: begin
                    if (is_digit) begin
                        claim_accum  = d[62:0];
                        claim_search = jwtexp_pkg::S_DIGIT;
                    end else if (c != jwtexp_pkg::CH_SPACE && c != jwtexp_pkg::CH_TAB) begin
                        claim_search = jwtexp_pkg::S_NODIG;
                    end
                end
                jwtexp_pkg::S_DIGIT: begin
                    if (!is_digit) begin
                        claim_search = jwtexp_pkg::S_DONE;
                    end else if (claim_sat ||
                                 {1'b0, claim_accum} >
                                 ({1'b0, jwtexp_pkg::ACC_MAX} - d) / 64'd10) begin
                        claim_accum = jwtexp_pkg::ACC_MAX;
                        claim_sat   = 1'b1;
                    end else begin
                        claim_accum = claim_accum * 63'd10 + d[62:0];
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void close_quartet();
        if (claim_pads < 3) feed_decoded(claim_bits[23:16]);
        if (claim_pads < 2) feed_decoded(claim_bits[15:8]);
        if (claim_pads < 1) feed_decoded(claim_bits[7:0]);
        claim_bits = '0;
        claim_fill = '0;
        claim_pads = '0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [5:0] sx;
        if (c >= "A" && c <= "Z") sx = 6'(c - "A");
        else if (c >= "a" && c <= "z") sx = 6'(c - "a" + 8'd26);
        else if (c >= jwtexp_pkg::CH_ZERO && c <= jwtexp_pkg::CH_NINE)
            sx = 6'(c - jwtexp_pkg::CH_ZERO + 8'd52);
        else if (c == jwtexp_pkg::CH_PLUS || c == jwtexp_pkg::CH_DASH) sx = 6'd62;
        else if (c == jwtexp_pkg::CH_SLASH || c == jwtexp_pkg::CH_UNDER) sx = 6'd63;
        else sx = 6'd0;
        claim_bits = claim_bits << 6;
        if (c == jwtexp_pkg::CH_PAD) claim_pads++;
        else claim_bits[5:0] = sx;
        claim_fill++;
        if (claim_fill >= 4) close_quartet();
    endfunction

    // Returns 1 when the byte closes a token, with the verdict it must produce
    function automatic bit predict_verdict(input jwtexp_pkg::t_in_item it,
                                           output jwtexp_pkg::t_out_item res);
        res = '{expired: 1'b1, verdict: jwtexp_pkg::VERD_NONE, expiry_value: '0,
                expiry_saturated: 1'b0};
        case (claim_seg)
            jwtexp_pkg::SEG_HEAD: begin
                if (it.token_byte == jwtexp_pkg::CH_DOT) claim_seg = jwtexp_pkg::SEG_BODY;
            end
            jwtexp_pkg::SEG_BODY: begin
                if (it.token_byte == jwtexp_pkg::CH_DOT) begin
                    if (claim_fill > 0) begin
                        while (claim_fill < 4) begin
                            claim_bits = claim_bits << 6;
                            claim_pads++;
                            claim_fill++;
                        end
                        close_quartet();
                    end
                    claim_seg = jwtexp_pkg::SEG_TAIL;
                end else begin
                    take_char(it.token_byte);
                end
            end
            default: ;
        endcase
        if (!it.last_byte) return 1'b0;
        if (claim_seg == jwtexp_pkg::SEG_TAIL && claim_nonempty) begin
            if (claim_search <= jwtexp_pkg::S_KEY4) begin
                res.verdict = jwtexp_pkg::VERD_NO_KEY;
                res.expired = 1'b0;
            end else if (claim_search == jwtexp_pkg::S_COLON) begin
                res.verdict = jwtexp_pkg::VERD_NO_COLON;
            end else if (claim_search == jwtexp_pkg::S_DIGIT ||
                         claim_search == jwtexp_pkg::S_DONE) begin
                res.verdict          = jwtexp_pkg::VERD_COMPARED;
                res.expiry_value     = claim_accum;
                res.expiry_saturated = claim_sat;
                res.expired = !it.time_now[63] &&
                              ($signed(it.time_now) >= $signed({1'b0, claim_accum}));
            end else begin
                res.verdict = jwtexp_pkg::VERD_NO_DIGIT;
            end
        end
        claim_reset();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : check_verdicts
        jwtexp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                note_error($sformatf("unexpected verdict %p", o_out_item));
            end else begin
                want = pending_verdicts.pop_front();
                tokens_seen++;
                if (want.verdict == jwtexp_pkg::VERD_COMPARED) n_compared++;
                if (want.expiry_saturated) n_saturated++;
                if (o_out_item.expired !== want.expired)
                    note_error($sformatf("expired: expected %0b, got %0b",
                                         want.expired, o_out_item.expired));
                if (o_out_item.verdict !== want.verdict)
                    note_error($sformatf("verdict: expected %0d, got %0d",
                                         want.verdict, o_out_item.verdict));
                if (o_out_item.expiry_value !== want.expiry_value)
                    note_error($sformatf("expiry_value: expected %0d, got %0d",
                                         want.expiry_value, o_out_item.expiry_value));
                if (o_out_item.expiry_saturated !== want.expiry_saturated)
                    note_error($sformatf("expiry_saturated: expected %0b, got %0b",
                                         want.expiry_saturated, o_out_item.expiry_saturated));
            end
        end
    end

    task automatic push_byte(input jwtexp_pkg::t_in_item item);
        jwtexp_pkg::t_out_item res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (predict_verdict(item, res)) pending_verdicts.push_back(res);
    endtask

    task automatic send_token(input t_bytes tok, input logic [63:0] now);
        jwtexp_pkg::t_in_item item;
        for (int i = 0; i < tok.size(); i++) begin
            item.token_byte = tok[i];
            item.last_byte  = (i == tok.size() - 1);
            item.time_now   = item.last_byte ? now : {$urandom, $urandom};
            push_byte(item);
        end
    endtask

    // Hold the sender until every verdict has come back
    task automatic wait_for_verdicts();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_bytes str_bytes(input string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_bytes b64_encode(input t_bytes raw, input bit pad, input int alt_pct);
        t_bytes      enc;
        logic [23:0] n;
        logic [5:0]  idx;
        logic [7:0]  c;
        int          left;
        bit          alt;
        for (int i = 0; i < raw.size(); i += 3) begin
            left = raw.size() - i;
            n = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
            for (int k = 0; k < 4; k++) begin
                if (k <= left) begin
                    idx = n[23-6*k -: 6];
                    alt = ($urandom_range(0, 99) < alt_pct);
                    if (idx < 26) c = "A" + {2'b0, idx};
                    else if (idx < 52) c = "a" + {2'b0, idx} - 8'd26;
                    else if (idx < 62) c = jwtexp_pkg::CH_ZERO + {2'b0, idx} - 8'd52;
                    else if (idx == 62) c = alt ? jwtexp_pkg::CH_DASH : jwtexp_pkg::CH_PLUS;
                    else c = alt ? jwtexp_pkg::CH_UNDER : jwtexp_pkg::CH_SLASH;
                    enc.push_back(c);
                end else if (pad) begin
                    enc.push_back(jwtexp_pkg::CH_PAD);
                end
            end
        end
        return enc;
    endfunction

    function automatic t_bytes jwt_of(input t_bytes hdr, input t_bytes claims, input bit pad,
                                      input int alt_pct, input t_bytes sig,
                                      input bit dot1, input bit dot2);
        t_bytes tok;
        t_bytes enc;
        tok = hdr;
        enc = b64_encode(claims, pad, alt_pct);
        if (dot1) tok.push_back(jwtexp_pkg::CH_DOT);
        foreach (enc[i]) tok.push_back(enc[i]);
        if (dot2) tok.push_back(jwtexp_pkg::CH_DOT);
        foreach (sig[i]) tok.push_back(sig[i]);
        return tok;
    endfunction

    function automatic logic [63:0] pick_now(input logic [63:0] val);
        case ($urandom_range(0, 6))
            0:       return val - 64'd1;
            1:       return val;
            2:       return val + 64'd1;
            3:       return {$urandom, $urandom};
            4:       return {1'b1, 31'($urandom), $urandom};
            5:       return {1'b0, jwtexp_pkg::ACC_MAX};
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    task automatic random_token();
        t_bytes      tok;
        t_bytes      hdr;
        t_bytes      sig;
        t_bytes      raw;
        string       dg;
        string       blanks;
        string       js;
        string       prefix;
        string       suffix;
        logic [63:0] val;
        logic [7:0]  b;
        int          kind;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                val = {32'($urandom_range(0, 255)), $urandom};
                dg  = $sformatf("%0d", val);
            end
            6: begin
                val = 64'($urandom_range(0, 999));
                dg  = $sformatf("000%0d", val);
            end
            7: begin
                val = {1'b0, jwtexp_pkg::ACC_MAX};
                dg  = $urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808";
            end
            8: begin
                val = {1'b0, jwtexp_pkg::ACC_MAX};
                dg  = "";
                repeat ($urandom_range(19, 26))
                    dg = $sformatf("%s%c", dg,
                                   8'(jwtexp_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            default: begin
                val = {1'b0, 31'($urandom), $urandom};
                dg  = $sformatf("%0d", val);
            end
        endcase
        blanks = "";
        repeat ($urandom_range(0, 3))
            blanks = $sformatf("%s%s", blanks, $urandom_range(0, 1) ? " " : "\t");
        case ($urandom_range(0, 4))
            0:       prefix = "";
            1:       prefix = "\"sub\":\"a\",";
            2:       prefix = "\"e\":0,";
            3:       prefix = "\"exq\":7,";
            default: prefix = "\"\"";
        endcase
        case ($urandom_range(0, 3))
            0:       suffix = "}";
            1:       suffix = ",\"a\":1}";
            2:       suffix = "x}";
            default: suffix = "";
        endcase
        kind = $urandom_range(0, 99);
        if (kind < 70) js = {"{", prefix, "\"exp\":", blanks, dg, suffix};
        else if (kind < 76) js = {"{\"exp\"", blanks, dg, "}"};
        else if (kind < 82) js = {"{", prefix, "\"exp\":", blanks, "\"x\"}"};
        else if (kind < 88) js = $urandom_range(0, 1) ? {"{\"ex\":", dg, "}"} : {"{\"EXP\":", dg};
        else js = "";
        raw = str_bytes(js);
        if (kind >= 88) begin
            repeat ($urandom_range(1, 12)) raw.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom);
            hdr.push_back((b == jwtexp_pkg::CH_DOT) ? jwtexp_pkg::CH_E : b);
        end
        repeat ($urandom_range(0, 6))
            sig.push_back(8'($urandom_range(0, 3) == 0 ? jwtexp_pkg::CH_DOT : $urandom));
        if (kind >= 94) begin
            // noise: random bytes with scattered dots
            repeat ($urandom_range(1, 15))
                tok.push_back($urandom_range(0, 4) == 0 ? jwtexp_pkg::CH_DOT : 8'($urandom));
        end else begin
            tok = jwt_of(hdr, raw, 1'($urandom_range(0, 1)), $urandom_range(0, 100), sig,
                         $urandom_range(0, 99) >= 3, $urandom_range(0, 99) >= 5);
            if ($urandom_range(0, 99) < 8) begin
                b = $urandom_range(0, 1) ? jwtexp_pkg::CH_PAD : 8'($urandom);
                tok.insert(hdr.size() + 1 + $urandom_range(0, raw.size()),
                           (b == jwtexp_pkg::CH_DOT) ? jwtexp_pkg::CH_PAD : b);
            end
        end
        send_token(tok, pick_now(val));
    endtask

    task automatic test_directed();
        t_bytes none;
        t_bytes tok;
        send_token(jwt_of(str_bytes("h"), str_bytes("{\"exp\":100}"), 1'b1, 0,
                          str_bytes("s"), 1'b1, 1'b1), 64'd100);
        send_token(jwt_of(none, str_bytes("{\"exp\":100}"), 1'b0, 0, none, 1'b1, 1'b1),
                   64'd99);
        send_token(jwt_of(str_bytes("hdr"), str_bytes("{\"exp\": \t100}"), 1'b1, 50,
                          str_bytes("sig"), 1'b1, 1'b1), 64'hFFFF_FFFF_FFFF_FFFB);
        send_token(jwt_of(none, str_bytes("{\"exp\":99999999999999999999999}"), 1'b0, 0,
                          str_bytes("x"), 1'b1, 1'b1), {1'b0, jwtexp_pkg::ACC_MAX});
        send_token(jwt_of(none, str_bytes("{\"exp\":9223372036854775807}"), 1'b1, 100,
                          none, 1'b1, 1'b1), 64'h8000_0000_0000_0000);
        send_token(jwt_of(none, str_bytes("{\"exp\" 5}"), 1'b1, 0, none, 1'b1, 1'b1), 64'd0);
        send_token(jwt_of(none, str_bytes("{\"exp\":\"x\"}"), 1'b1, 0, none, 1'b1, 1'b1),
                   64'd0);
        send_token(jwt_of(none, str_bytes("{\"EXP\":1}"), 1'b1, 0, none, 1'b1, 1'b1), 64'd0);
        send_token(jwt_of(none, str_bytes("{\"\"exp\":7}"), 1'b0, 0, none, 1'b1, 1'b1),
                   64'd7);
        // foreign characters and both alphabets
        send_token(str_bytes(".-_+/*~==."), 64'd0);
        // padding in odd places, all-pad quartet, empty payload
        send_token(str_bytes(".=AAA."), 64'd0);
        send_token(str_bytes(".A=A=."), 64'd0);
        send_token(str_bytes(".====."), 64'd0);
        send_token(str_bytes(".."), 64'd0);
        // no second dot
        send_token(str_bytes(".eyJleHAiOjF9"), 64'd0);
        tok = jwt_of(none, str_bytes("{\"exp\":1}"), 1'b0, 0, str_bytes("a.b."), 1'b1, 1'b1);
        tok.push_front(8'hFF);
        tok.push_front(8'h00);
        send_token(tok, 64'd2);
        wait_for_verdicts();
    endtask

    task automatic test_random_tokens(input int n_bytes);
        int start;
        int made;
        start = bytes_sent;
        made  = 0;
        while (bytes_sent - start < n_bytes || made < 16) begin
            random_token();
            made++;
        end
        wait_for_verdicts();
    endtask

    // Freeze the output side so verdicts pile up and the input stalls
    task automatic test_backpressure();
        t_bytes tok;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (40) begin
            tok.delete();
            repeat ($urandom_range(1, 3))
                tok.push_back($urandom_range(0, 1) ? jwtexp_pkg::CH_DOT : 8'($urandom));
            send_token(tok, {$urandom, $urandom});
        end
        repeat (6) random_token();
        wait_for_verdicts();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        claim_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 34;
        recv_stall_pct = 52;
        test_directed();
        test_random_tokens(250);
        send_idle_pct  = 52;
        recv_stall_pct = 34;
        test_random_tokens(250);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_tokens(250);
        test_backpressure();

        wait_for_verdicts();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d verdicts over %0d token bytes (%0d compared, %0d saturated).",
                 tokens_seen, bytes_sent, n_compared, n_saturated);
        $display("Traffic ran with sender-heavy, receiver-heavy and no idling, plus a long hold-off.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/jwtexp_pkg.sv
sv/jwtexp_match.sv
sv/jwt_expiry_stream_check_core.sv
tb/tb.sv
